// ===== src/atts_pkg.sv =====
// shared types and constants for the alarm table track scheduler
package atts_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int TRACK_W  = 8;
  localparam int MODE_W   = 2;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CHECK = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TRACK_W-1:0]  track;
    logic [SECOND_W-1:0] second;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
  } entry_t;

endpackage

// ===== src/alarm_table_track_scheduler_top.sv =====
// alarm table: add, clear and time-check words over one entry memory
//
// channel  dir  fields
// s_*      in   tuser: mode; tdata: hour, minute, second, track
// m_*      out  tuser: match, rejected; tdata: play_track
//
// clear, add, unused mode and a check off second zero finish in the accept cycle
// a check at second zero scans the entry memory's single read port one entry per
// cycle; each read is registered before its compare, and the result is then loaded
// into the output register
// reset clears the valid flags at once; no clearing pass is needed
// a finished result waits in the output register; the next word is taken while it drains
module alarm_table_track_scheduler_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [atts_pkg::IN_DATA_W-1:0]  s_tdata,   // hour, minute, second, track, zero fill
  input  logic [atts_pkg::MODE_W-1:0]     s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [atts_pkg::OUT_DATA_W-1:0] m_tdata,   // play_track
  output logic [atts_pkg::OUT_USER_W-1:0] m_tuser    // match, rejected
);
  import atts_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t state, state_next;

  entry_t                 mem [TABLE_DEPTH];
  entry_t                 mem_q;
  logic [TABLE_DEPTH-1:0] entry_valid;

  entry_t     in_entry;
  mode_t      in_mode;
  logic       accept;
  logic       out_free;
  logic       table_full;
  logic [IDX_W-1:0] free_idx;
  logic       mem_we;

  logic [HOUR_W-1:0]   cur_hour;
  logic [MINUTE_W-1:0] cur_minute;
  logic [IDX_W-1:0]    scan_addr;
  logic                scan_on;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_vld;
  logic                hit;
  logic                found;
  logic [TRACK_W-1:0]  found_track;

  assign in_entry = entry_t'(s_tdata[$bits(entry_t)-1:0]);
  assign in_mode  = mode_t'(s_tuser);
  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign mem_we   = accept && (in_mode == MODE_ADD) && !table_full;

  // lowest free entry
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!entry_valid[i]) free_idx = IDX_W'(i);
    end
  end
  assign table_full = &entry_valid;

  assign hit = rd_vld && entry_valid[rd_idx] &&
               (mem_q.hour == cur_hour) && (mem_q.minute == cur_minute);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = out_free;
        if (s_tvalid && out_free && in_mode == MODE_CHECK && in_entry.second == '0)
          state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_vld && rd_idx == LAST_IDX) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[free_idx] <= in_entry;
    mem_q <= mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      m_tvalid    <= 1'b0;
      scan_on     <= 1'b0;
      rd_vld      <= 1'b0;
    end else begin
      if (accept) begin
        // a check at second zero holds its word back until the scan ends
        m_tvalid <= !(in_mode == MODE_CHECK && in_entry.second == '0);
        m_tdata  <= '0;
        m_tuser  <= {(in_mode == MODE_ADD) && table_full, 1'b0};
        case (in_mode)
          MODE_CLEAR: entry_valid <= '0;
          MODE_ADD: begin
            if (!table_full) entry_valid[free_idx] <= 1'b1;
          end
          MODE_CHECK: begin
            if (in_entry.second == '0) begin
              cur_hour   <= in_entry.hour;
              cur_minute <= in_entry.minute;
              scan_addr  <= '0;
              scan_on    <= 1'b1;
              found      <= 1'b0;
              found_track <= '0;
            end
          end
          default: ;
        endcase
      end else if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= found_track;
        m_tuser  <= {1'b0, found};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // issue one read per cycle, compare it in the following cycle
      rd_vld <= scan_on;
      if (scan_on) begin
        rd_idx <= scan_addr;
        if (scan_addr == LAST_IDX) scan_on <= 1'b0;
        else                       scan_addr <= scan_addr + 1'b1;
      end

      if (hit) begin
        found       <= 1'b1;
        found_track <= mem_q.track;
      end
    end
  end

  // valid reads of the entry memory (rd_vld) only happen during a scan
  assert property (@(posedge clk) disable iff (rst) rd_vld |-> state == ST_SCAN)
    else $error("entry read outside scan");

  // a check at second zero starts a scan
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_mode == MODE_CHECK && in_entry.second == '0) |=> state == ST_SCAN)
    else $error("check did not start scan");

  // a rejected add only reports while the table is full
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> table_full)
    else $error("rejected with free entry");

  // match and rejected never together
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("match and rejected both set");

endmodule

// ===== tb/alarm_check.sv =====
// checker: predicts each result from accepted words and compares the output stream
`timescale 1ns / 1ps

module alarm_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [atts_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [atts_pkg::MODE_W-1:0]     s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [atts_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [atts_pkg::OUT_USER_W-1:0] m_tuser,
  output int                              mismatch_count,
  output int                              results_owed
);
  import atts_pkg::*;

  typedef struct packed {
    logic               match;
    logic [TRACK_W-1:0] play_track;
    logic               rejected;
  } alarm_result_t;

  entry_t                 alarm_tab [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] alarm_live;
  alarm_result_t          results_q [$];
  alarm_result_t          oldest;
  alarm_result_t          fresh;
  int                     err_total = 0;

  initial begin
    mismatch_count = 0;
    results_owed = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    err_total++;
  endtask

  // updates the table copy and returns the result the block owes for this word
  task automatic predict_alarm(input logic [MODE_W-1:0] mode, input logic [IN_DATA_W-1:0] word,
                               output alarm_result_t res);
    entry_t e;
    int     slot;
    e.hour   = word[4:0];
    e.minute = word[10:5];
    e.second = word[16:11];
    e.track  = word[24:17];
    res = '0;
    slot = -1;
    case (mode)
      MODE_CLEAR: begin
        alarm_live = '0;
      end
      MODE_ADD: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (!alarm_live[i] && slot < 0) slot = i;
        if (slot < 0) begin
          res.rejected = 1'b1;
        end else begin
          alarm_tab[slot] = e;
          alarm_live[slot] = 1'b1;
        end
      end
      MODE_CHECK: begin
        // stored second is ignored; only a check at second zero can hit
        if (e.second == '0) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (alarm_live[i] && alarm_tab[i].hour == e.hour &&
                alarm_tab[i].minute == e.minute) begin
              res.match = 1'b1;
              res.play_track = alarm_tab[i].track;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      alarm_live = '0;
      results_q.delete();
    end else begin
      // output side first so a word never meets an expectation of the same edge
      if (m_tvalid && m_tready) begin
        if (results_q.size() == 0) begin
          report_mismatch("word with nothing expected", m_tdata, 8'h00);
        end else begin
          oldest = results_q.pop_front();
          if (m_tuser[0] !== oldest.match)
            report_mismatch("match", 8'(m_tuser[0]), 8'(oldest.match));
          if (m_tdata !== oldest.play_track)
            report_mismatch("play_track", m_tdata, oldest.play_track);
          if (m_tuser[1] !== oldest.rejected)
            report_mismatch("rejected", 8'(m_tuser[1]), 8'(oldest.rejected));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_alarm(s_tuser, s_tdata, fresh);
        results_q.push_back(fresh);
      end
    end
    results_owed <= results_q.size();
    mismatch_count <= err_total;
  end

endmodule

// ===== tb/testbench.sv =====
// stimulus, flow control and verdict for the alarm table track scheduler
`timescale 1ns / 1ps

module testbench;
  import atts_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_WORDS   = 1030;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 2 * TABLE_DEPTH + 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [MODE_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  int mismatch_count;
  int results_owed;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alarm_table_track_scheduler_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  alarm_check u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_done = 1'b1;
      end
      m_tready <= !rst && (quiet || $urandom_range(0, 99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // optional random gap, then hold the word until it is taken
  task automatic offer_word(input logic [MODE_W-1:0] mode, input logic [HOUR_W-1:0] hr,
                            input logic [MINUTE_W-1:0] mn, input logic [SECOND_W-1:0] sec,
                            input logic [TRACK_W-1:0] trk);
    if (!quiet && $urandom_range(0, 99) < 17) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tuser  <= mode;
    s_tdata  <= {7'd0, trk, sec, mn, hr};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  initial begin : stimulus
    int                  counted;
    int                  pick;
    logic [HOUR_W-1:0]   hr;
    logic [MINUTE_W-1:0] mn;
    logic [SECOND_W-1:0] sec;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, field extremes, out-of-range values, unused mode
    offer_word(MODE_CHECK, 5'd0, 6'd0, 6'd0, 8'd0);
    offer_word(MODE_ADD, 5'd0, 6'd0, 6'd0, 8'd0);
    offer_word(MODE_ADD, 5'd31, 6'd63, 6'd63, 8'd255);
    offer_word(MODE_ADD, 5'd23, 6'd59, 6'd59, 8'd128);
    offer_word(MODE_CHECK, 5'd31, 6'd63, 6'd0, 8'd0);
    offer_word(MODE_CHECK, 5'd31, 6'd63, 6'd1, 8'd0);
    offer_word(MODE_CHECK, 5'd0, 6'd0, 6'd0, 8'd255);
    offer_word(MODE_CHECK, 5'd23, 6'd59, 6'd63, 8'd0);
    offer_word(MODE_UNUSED, 5'd31, 6'd63, 6'd63, 8'd255);
    // fill the remaining entries with one alarm time so the highest entry wins
    for (int i = 0; i < TABLE_DEPTH - 3; i++)
      offer_word(MODE_ADD, 5'd5, 6'd30, 6'(i), 8'(8'h40 + i));
    offer_word(MODE_ADD, 5'd1, 6'd1, 6'd0, 8'd7);
    offer_word(MODE_CHECK, 5'd5, 6'd30, 6'd0, 8'd0);
    offer_word(MODE_CLEAR, 5'd31, 6'd63, 6'd63, 8'd255);
    offer_word(MODE_CHECK, 5'd5, 6'd30, 6'd0, 8'd0);

    counted = 0;
    while (counted < RANDOM_WORDS) begin
      quiet = (counted >= 300 && counted < 450);
      if (counted == 200) hold_req = 1'b1;
      if (counted == 600) drain_results();
      pick = $urandom_range(0, 99);
      // mostly a small pool of times so checks hit stored alarms
      hr  = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      mn  = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 2)) : 6'($urandom);
      sec = 6'($urandom);
      if (pick < 4) begin
        offer_word(MODE_CLEAR, hr, mn, sec, 8'($urandom));
        counted++;
      end else if (pick < 40) begin
        offer_word(MODE_ADD, hr, mn, sec, 8'($urandom));
        counted++;
      end else if (pick < 95) begin
        if ($urandom_range(0, 99) < 75) sec = '0;
        offer_word(MODE_CHECK, hr, mn, sec, 8'($urandom));
        counted++;
      end else begin
        offer_word(MODE_UNUSED, hr, mn, sec, 8'($urandom));
        counted++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
